>>> hdl/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, constants and the token class decoder of the token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Buffer and counter limits
  localparam int MAX_TOKENS    = 1024;
  localparam int WORD_BUFFER   = 64;
  localparam int STRING_BUFFER = 256;
  localparam int TOK_W         = $clog2(MAX_TOKENS + 1);

  localparam logic [7:0]       WORD_LIMIT   = 8'(WORD_BUFFER - 1);
  localparam logic [7:0]       STRING_LIMIT = 8'(STRING_BUFFER - 1);
  localparam logic [TOK_W-1:0] TOK_MAX      = TOK_W'(MAX_TOKENS);
  localparam logic [15:0]      LOC_MAX      = 16'hFFFF;
  localparam logic [15:0]      LOC_FIRST    = 16'd1;

  // Special bytes
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PRN_LO  = 8'h21;
  localparam logic [7:0] CH_PRN_HI  = 8'h7E;

  // Result kinds
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd3;
  localparam logic [2:0] ERR_UNTERM    = 3'd4;

  // Token classes
  localparam logic [3:0] CLS_KEYWORD  = 4'd0;
  localparam logic [3:0] CLS_TYPE     = 4'd1;
  localparam logic [3:0] CLS_VAR      = 4'd2;
  localparam logic [3:0] CLS_FUNCTION = 4'd3;
  localparam logic [3:0] CLS_BEGIN    = 4'd4;
  localparam logic [3:0] CLS_END      = 4'd5;
  localparam logic [3:0] CLS_SEP      = 4'd6;
  localparam logic [3:0] CLS_DISC     = 4'd7;
  localparam logic [3:0] CLS_ASSIGN   = 4'd8;
  localparam logic [3:0] CLS_PUT      = 4'd9;
  localparam logic [3:0] CLS_AT       = 4'd10;
  localparam logic [3:0] CLS_DEREF    = 4'd11;
  localparam logic [3:0] CLS_META     = 4'd12;
  localparam logic [3:0] CLS_NUMBER   = 4'd13;
  localparam logic [3:0] CLS_STRING   = 4'd14;
  localparam logic [3:0] CLS_UNKNOWN  = 4'd15;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STRING,
    MODE_COMMENT
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_stream;
  } stl_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  char_byte;
    logic [3:0]  token_class;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  token_length;
    logic [9:0]  token_index;
    logic [2:0]  error_code;
  } stl_out_t;

  // Core status seen by the top level
  typedef struct packed {
    lex_mode_e          mode;
    logic [15:0]        line;
    logic [15:0]        column;
    logic [TOK_W-1:0]   tokens;
  } stl_stat_t;

  // Map the first character of a word to its class
  function automatic logic [3:0] stl_classify(input logic [7:0] c);
    logic [3:0] cls;
    cls = CLS_UNKNOWN;
    unique case (c)
      8'h5F: cls = CLS_KEYWORD;
      8'h3A: cls = CLS_TYPE;
      8'h24: cls = CLS_VAR;
      8'h40: cls = CLS_FUNCTION;
      8'h5B: cls = CLS_BEGIN;
      8'h5D: cls = CLS_END;
      8'h7C: cls = CLS_SEP;
      8'h21: cls = CLS_DISC;
      8'h3D: cls = CLS_ASSIGN;
      8'h2E: cls = CLS_PUT;
      8'h2C: cls = CLS_AT;
      8'h2A: cls = CLS_DEREF;
      8'h2F: cls = CLS_META;
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h35, 8'h36, 8'h37, 8'h38, 8'h39: cls = CLS_NUMBER;
      default: cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

>>> hdl/source_token_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer_unit
// Splits a byte stream into tokens and reports characters, finished tokens
// and errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o / in_req_i carries one source byte
//   per request, or an end-of-stream marker. Output channel out_valid_o /
//   out_ready_i / out_res_o carries at most one result per request.
//   Each request is processed in the cycle it is accepted; its result, if
//   any, appears on out_res_o in the next cycle from the result register.
//   Throughput is one request per cycle while the receiver keeps up.
//   Requests that give no result (comment bytes, spaces between tokens,
//   an opening quote) pass through without using the result register.
//   When the receiver stalls, the result register holds its value and
//   in_ready_o drops until the result is taken; in_ready_o rises again in
//   the same cycle that out_ready_i takes the result.
//   Reset clears the mode, counts and token counter and puts the location
//   at line 1, column 1; no result is pending after reset.
//   End of stream resets the location but keeps the token counter.
// ----------------------------------------------------------------------------
module source_token_lexer_unit import stl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  stl_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output stl_out_t out_res_o
);

  logic      accept;
  logic      core_valid;
  stl_out_t  core_res;
  stl_stat_t core_stat;

  // Accept a request when the result register has room
  assign accept = in_valid_i && in_ready_o;

  stl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .req_i      (in_req_i),
    .res_valid_o(core_valid),
    .res_o      (core_res),
    .stat_o     (core_stat)
  );

  stl_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept && core_valid),
    .data_i (core_res),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_res_o)
  );

  // End of stream returns the lexer to idle at the first location
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_req_i.end_of_stream |=>
      core_stat.mode == MODE_IDLE && core_stat.line == LOC_FIRST &&
      core_stat.column == LOC_FIRST)
    else $error("lexer not reset by end of stream");

  // Token counter never passes its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.tokens <= TOK_MAX)
    else $error("token counter beyond limit");

  // Counter moves only on an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(core_stat.tokens))
    else $error("token counter changed without a request");

  // A request with a result always shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && core_valid |=> out_valid_o)
    else $error("result lost");

endmodule

>>> hdl/stl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_core
// Lexer state registers and the single-pass step logic that turns one
// request into the next state and at most one result.
// ----------------------------------------------------------------------------
module stl_core import stl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  stl_in_t   req_i,
  output logic      res_valid_o,
  output stl_out_t  res_o,
  output stl_stat_t stat_o
);

  lex_mode_e        mode_q, mode_d;
  logic             skip_q, skip_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       count_q, count_d;
  logic [15:0]      line_q, line_d;
  logic [15:0]      col_q, col_d;
  logic [TOK_W-1:0] tokens_q, tokens_d;

  logic [7:0]  b;
  logic        eos;
  logic        is_print;
  logic        plain_mode;
  logic        open_cmt;
  logic        str_store;
  logic        str_close;
  logic        start_str;
  logic        word_store;
  logic        word_finish;
  logic        do_finish;
  logic        do_advance;
  logic [3:0]  fin_cls;
  logic        fin_full;
  logic        fin_ok;
  logic [7:0]  count_eff;
  logic [7:0]  limit;
  logic        store_ok;
  logic [15:0] line_adv;
  logic [15:0] col_adv;

  // Decode the request against the current mode
  assign b           = req_i.source_byte;
  assign eos         = req_i.end_of_stream;
  assign is_print    = (b >= CH_PRN_LO) && (b <= CH_PRN_HI);
  assign plain_mode  = (mode_q == MODE_IDLE) || (mode_q == MODE_WORD);
  assign open_cmt    = plain_mode && (b == CH_SEMI) && !skip_q;
  assign str_store   = (mode_q == MODE_STRING) && ((count_q == 8'd0) || (b != CH_QUOTE));
  assign str_close   = (mode_q == MODE_STRING) && !str_store;
  assign start_str   = plain_mode && !open_cmt && is_print &&
                       (mode_q == MODE_IDLE) && (b == CH_QUOTE);
  assign word_store  = plain_mode && !open_cmt && is_print && !start_str;
  assign word_finish = (mode_q == MODE_WORD) && !open_cmt && !is_print;
  assign do_advance  = str_close || (plain_mode && !open_cmt && !start_str);

  // Finish check: counter limit first, then unknown class
  assign fin_cls   = (mode_q == MODE_STRING) ? CLS_STRING : stl_classify(first_q);
  assign do_finish = eos ? (mode_q == MODE_WORD) : (str_close || word_finish);
  assign fin_full  = (tokens_q >= TOK_MAX);
  assign fin_ok    = !fin_full && (fin_cls != CLS_UNKNOWN);

  // Character store limit
  assign count_eff = (mode_q == MODE_IDLE) ? 8'd0 : count_q;
  assign limit     = (mode_q == MODE_STRING) ? STRING_LIMIT : WORD_LIMIT;
  assign store_ok  = count_eff < limit;

  // Location advance with saturation
  always_comb begin
    line_adv = line_q;
    col_adv  = col_q;
    if (b == CH_NEWLINE) begin
      if (line_q < LOC_MAX) line_adv = line_q + 16'd1;
      col_adv = LOC_FIRST;
    end else if (col_q < LOC_MAX) begin
      col_adv = col_q + 16'd1;
    end
  end

  // Next state
  always_comb begin
    mode_d   = mode_q;
    skip_d   = skip_q;
    first_d  = first_q;
    count_d  = count_q;
    line_d   = line_q;
    col_d    = col_q;
    tokens_d = tokens_q;
    if (do_finish && fin_ok) tokens_d = tokens_q + TOK_W'(1);
    if (eos) begin
      mode_d  = MODE_IDLE;
      skip_d  = 1'b0;
      first_d = 8'd0;
      count_d = 8'd0;
      line_d  = LOC_FIRST;
      col_d   = LOC_FIRST;
    end else begin
      unique case (mode_q)
        MODE_COMMENT: begin
          if (b == CH_SEMI) begin
            mode_d = (count_q != 8'd0) ? MODE_WORD : MODE_IDLE;
            skip_d = 1'b1;
          end
        end
        MODE_STRING: begin
          if (str_store) begin
            if (store_ok) count_d = count_q + 8'd1;
          end else begin
            mode_d  = MODE_IDLE;
            count_d = 8'd0;
            first_d = 8'd0;
          end
        end
        MODE_IDLE, MODE_WORD: begin
          if (open_cmt) begin
            mode_d = MODE_COMMENT;
          end else begin
            skip_d = 1'b0;
            if (is_print) begin
              if (mode_q == MODE_IDLE) begin
                first_d = b;
                mode_d  = start_str ? MODE_STRING : MODE_WORD;
              end
              count_d = count_eff;
              if (word_store && store_ok) count_d = count_eff + 8'd1;
            end else if (mode_q == MODE_WORD) begin
              mode_d  = MODE_IDLE;
              count_d = 8'd0;
              first_d = 8'd0;
            end
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
      if (do_advance) begin
        line_d = line_adv;
        col_d  = col_adv;
      end
    end
  end

  // Result of this request
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (eos) begin
      if (mode_q == MODE_STRING || mode_q == MODE_COMMENT) begin
        res_valid_o         = 1'b1;
        res_o.result_kind   = KIND_ERROR;
        res_o.token_class   = CLS_UNKNOWN;
        res_o.line_number   = line_q;
        res_o.column_number = col_q;
        res_o.token_length  = count_q;
        res_o.token_index   = tokens_q[9:0];
        res_o.error_code    = ERR_UNTERM;
      end
    end else if (str_store || word_store) begin
      res_valid_o     = 1'b1;
      res_o.char_byte = b;
      if (store_ok) begin
        res_o.result_kind = KIND_CHAR;
      end else begin
        res_o.result_kind = KIND_ERROR;
        res_o.error_code  = ERR_TOO_LONG;
      end
    end
    if (do_finish) begin
      res_valid_o         = 1'b1;
      res_o.token_class   = fin_cls;
      res_o.line_number   = line_q;
      res_o.column_number = col_q;
      res_o.token_length  = count_q;
      res_o.token_index   = tokens_q[9:0];
      if (fin_full) begin
        res_o.result_kind = KIND_ERROR;
        res_o.error_code  = ERR_TOO_MANY;
      end else if (fin_cls == CLS_UNKNOWN) begin
        res_o.result_kind = KIND_ERROR;
        res_o.error_code  = ERR_UNKNOWN;
      end else begin
        res_o.result_kind = KIND_FINISH;
        res_o.error_code  = ERR_NONE;
      end
    end
  end

  // Update state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      skip_q   <= 1'b0;
      first_q  <= 8'd0;
      count_q  <= 8'd0;
      line_q   <= LOC_FIRST;
      col_q    <= LOC_FIRST;
      tokens_q <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      skip_q   <= skip_d;
      first_q  <= first_d;
      count_q  <= count_d;
      line_q   <= line_d;
      col_q    <= col_d;
      tokens_q <= tokens_d;
    end
  end

  assign stat_o.mode   = mode_q;
  assign stat_o.line   = line_q;
  assign stat_o.column = col_q;
  assign stat_o.tokens = tokens_q;

endmodule

>>> hdl/stl_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_out_reg
// Result register: holds one result until the receiver takes it and
// reloads in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
module stl_out_reg import stl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  stl_out_t data_i,
  output logic     ready_o,
  output logic     valid_o,
  input  logic     ready_i,
  output stl_out_t data_o
);

  logic     valid_q, valid_d;
  stl_out_t data_q;

  // Free when empty or being drained this cycle
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
